// File: src/ptsr_pkg.sv
`default_nettype none

package ptsr_pkg;

  localparam int unsigned MAX_STREAMS_DEF = 16;

  localparam int unsigned SID_W = 4;
  localparam int unsigned TS_W  = 64;
  localparam int unsigned DUR_W = 32;

  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef logic [SID_W-1:0] sid_t;
  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [DUR_W-1:0] dur_t;

  // per-stream entry of one bank
  typedef struct packed {
    ts_t  offset;
    ts_t  tail_dts;
    dur_t last_dur;
  } entry_t;

  // durations of zero or less count as one tick
  function automatic ts_t eff_dur(input dur_t d);
    ts_t r;
    if (d == '0 || d[DUR_W-1]) begin
      r = TS_W'(1);
    end else begin
      r = TS_W'(d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/packet_timestamp_rebaser.sv
`default_nettype none
// Packet timestamp rebaser for joining several input files into one stream.
// Slave channel: tuser = kind (0 packet, 1 start of next input file), tdata =
// stream id, dts, pts, duration. Master channel: tdata = stream, corrected
// dts, corrected pts; tuser = joined, discontinuity flags.
// Each stream keeps offset, last dts and last duration in a current and a
// previous bank, two synchronous RAMs swapped by a bank pointer on a
// new-file word. A new-file word and a packet on a stream outside
// MAX_STREAMS yield no output word.
// From input accept, the RAM read is registered with the input registers,
// then the update goes into the output register. Throughput: one word per
// cycle while the receiver takes them, set by the single read-modify-write
// per packet; the packet just ahead forwards its written entry to the next.
// Reset clears valid bits and the bank pointer; RAM contents are not
// cleared and need no clearing pass. When the receiver stalls, the output
// register holds its word, the word behind it waits in the update stage and
// tready drops only while both are full.
module packet_timestamp_rebaser #(
  parameter int unsigned MAX_STREAMS = ptsr_pkg::MAX_STREAMS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [3:0] stream_id, [67:4] pkt_dts, [131:68] pkt_pts, [163:132] pkt_duration
  input  wire logic [ptsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] kind
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [3:0] stream, [67:4] out_dts, [131:68] out_pts, [135:132] zero
  output logic [ptsr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // [0] joined, [1] discontinuity
  output logic [ptsr_pkg::OUT_TUSER_W-1:0]        m_axis_tuser_o
);
  import ptsr_pkg::*;

  localparam int unsigned AW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

  entry_t bank0_mem [MAX_STREAMS];
  entry_t bank1_mem [MAX_STREAMS];

  logic   in_acc;
  sid_t   in_sid;
  ts_t    in_dts, in_pts;
  dur_t   in_dur;
  logic [AW-1:0] in_addr;

  logic   s1_valid_q, s1_kind_q;
  sid_t   s1_sid_q;
  ts_t    s1_dts_q, s1_pts_q, s1_pd_q;
  dur_t   s1_dur_q;
  entry_t rd0_q, rd1_q;

  logic          fwd_valid_q, fwd_bank_q;
  logic [AW-1:0] fwd_addr_q;
  entry_t        fwd_data_q;

  logic                   sel_q, has_prev_q;
  logic [MAX_STREAMS-1:0] cur_valid_q, prev_valid_q;

  logic          m_valid_q;
  sid_t          m_sid_q;
  ts_t           m_dts_q, m_pts_q;
  logic          m_joined_q, m_disc_q;

  logic          s1_adv, in_range, wr_en;
  logic [AW-1:0] s1_addr;
  entry_t        b0, b1, cur_e, prv_e, wdata;
  logic          cv, pv, have_last, joined, disc, keep;
  ts_t           last_sel, eff, le, cand, off_b, res_dts, res_off, res_pts;
  dur_t          dur_sel;

  assign in_sid  = s_axis_tdata_i[3:0];
  assign in_dts  = s_axis_tdata_i[67:4];
  assign in_pts  = s_axis_tdata_i[131:68];
  assign in_dur  = s_axis_tdata_i[163:132];
  assign in_addr = AW'(in_sid);

  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_addr  = AW'(s1_sid_q);
    in_range = (32'(s1_sid_q) < MAX_STREAMS);

    b0 = (fwd_valid_q && !fwd_bank_q && fwd_addr_q == s1_addr) ? fwd_data_q : rd0_q;
    b1 = (fwd_valid_q &&  fwd_bank_q && fwd_addr_q == s1_addr) ? fwd_data_q : rd1_q;
    cur_e = sel_q ? b1 : b0;
    prv_e = sel_q ? b0 : b1;

    cv = in_range && cur_valid_q[s1_addr];
    pv = in_range && has_prev_q && prev_valid_q[s1_addr];
    have_last = cv || pv;
    joined    = !cv && pv;

    last_sel = cv ? cur_e.tail_dts : prv_e.tail_dts;
    dur_sel  = cv ? cur_e.last_dur : prv_e.last_dur;
    eff      = eff_dur(dur_sel);
    le       = last_sel + eff;
    cand     = s1_dts_q + cur_e.offset;
    off_b    = le - s1_dts_q;

    if (cv) begin
      disc = ($signed(last_sel) >= $signed(cand));
    end else begin
      disc = pv && ($signed(last_sel) >= $signed(le));
    end
    keep = cv && !disc;

    if (keep) begin
      res_dts = cand;
      res_off = cur_e.offset;
      res_pts = s1_pts_q + cur_e.offset;
    end else if (have_last) begin
      res_dts = le;
      res_off = off_b;
      res_pts = s1_pd_q + last_sel + eff;
    end else begin
      res_dts = '0;
      res_off = TS_W'(0) - s1_dts_q;
      res_pts = s1_pd_q;
    end

    wr_en          = s1_adv && !s1_kind_q && in_range;
    wdata.offset   = res_off;
    wdata.tail_dts = res_dts;
    wdata.last_dur = s1_dur_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !sel_q) begin
      bank0_mem[s1_addr] <= wdata;
    end
    if (in_acc) begin
      rd0_q <= bank0_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && sel_q) begin
      bank1_mem[s1_addr] <= wdata;
    end
    if (in_acc) begin
      rd1_q <= bank1_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      sel_q        <= 1'b0;
      has_prev_q   <= 1'b0;
      cur_valid_q  <= '0;
      prev_valid_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= wr_en;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_kind_q) begin
        sel_q        <= ~sel_q;
        prev_valid_q <= cur_valid_q;
        cur_valid_q  <= '0;
        has_prev_q   <= 1'b1;
      end else if (wr_en) begin
        cur_valid_q[s1_addr] <= 1'b1;
      end
      if (wr_en) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= s_axis_tuser_i;
      s1_sid_q   <= in_sid;
      s1_dts_q   <= in_dts;
      s1_pts_q   <= in_pts;
      s1_pd_q    <= in_pts - in_dts;
      s1_dur_q   <= in_dur;
      fwd_bank_q <= sel_q;
      fwd_addr_q <= s1_addr;
      fwd_data_q <= wdata;
    end
    if (wr_en) begin
      m_sid_q    <= s1_sid_q;
      m_dts_q    <= res_dts;
      m_pts_q    <= res_pts;
      m_joined_q <= joined;
      m_disc_q   <= disc;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0, m_pts_q, m_dts_q, m_sid_q};
  assign m_axis_tuser_o  = {m_disc_q, m_joined_q};

endmodule

`default_nettype wire
